// ----- design/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the resampler top module.
// Define ASSERT_OFF to compile every check away. Macros expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked out of reset only
`define LIR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define LIR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LIR_ASSERT(label, prop, msg)
`define LIR_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- design/lir_pkg.sv -----
// lir_pkg: types, widths and constants of the linear interpolation resampler.
// No dependencies; used by every other design file but assert_macros.svh.
package lir_pkg;

    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_RESULTS = 64;
    localparam int STEP_BITS   = 21;

    // phase accumulator holds phase (< 1.0) plus a full step
    localparam int PHASE_W = STEP_BITS + 1;
    localparam int CNT_W   = $clog2(MAX_RESULTS);
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int PROD_W  = DIFF_W + FRAC_BITS;

    localparam logic [PHASE_W-1:0]   PHASE_ONE   = PHASE_W'(64'd1 << FRAC_BITS);
    localparam logic [PHASE_W-1:0]   PHASE_BOUND = PHASE_W'(64'd1 << STEP_BITS);
    localparam logic [STEP_BITS-1:0] MIN_STEP    =
        STEP_BITS'((64'd1 << FRAC_BITS) / MAX_RESULTS);
    localparam logic [STEP_BITS-1:0] STEP_RESET  = STEP_BITS'(64'd1 << FRAC_BITS);
    localparam logic [CNT_W-1:0]     CNT_LAST    = CNT_W'(MAX_RESULTS - 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [CHANNELS-1:0]        frame_t;
    typedef logic [FRAC_BITS-1:0]          frac_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    // controls fanned out to every lane
    typedef struct packed
    {
        logic load_cur;   // capture incoming frame as current
        logic load_prev;  // priming frame goes straight to previous
        logic commit;     // frame done: current becomes previous
        logic advance;    // pipeline moves one slot
    } lane_ctl_t;

    // stage-1 slot status handed to the merge stage
    typedef struct packed
    {
        logic valid;
        logic last;
    } beat_ctl_t;

endpackage

// ----- design/lir_in_if.sv -----
// lir_in_if: input frame channel, one beat per frame.
// Depends on lir_pkg for the sample type.
interface lir_in_if;
    logic              valid;
    logic              ready;
    lir_pkg::sample_t  sample_ch0;
    lir_pkg::sample_t  sample_ch1;

    modport source (output valid, output sample_ch0, output sample_ch1, input ready);
    modport sink   (input valid, input sample_ch0, input sample_ch1, output ready);
endinterface

// ----- design/lir_out_if.sv -----
// lir_out_if: output sample channel, one beat per interpolated frame.
// Depends on lir_pkg for the sample type.
interface lir_out_if;
    logic              valid;
    logic              ready;
    lir_pkg::sample_t  out_ch0;
    lir_pkg::sample_t  out_ch1;
    logic              last;

    modport source (output valid, output out_ch0, output out_ch1, output last, input ready);
    modport sink   (input valid, input out_ch0, input out_ch1, input last, output ready);
endinterface

// ----- design/linear_interp_resampler.sv -----
// linear_interp_resampler: two-channel linear-interpolation sample rate converter.
// A frame's first output beat goes through the run state, the stage-1 registers and the output register.
// Throughput: the input is not ready again until the frame's outputs, if any, are all
//   issued; one output per cycle, stalled by output backpressure.
// Reset: async active low; clears phase, primed flag, previous frame and pipeline
//   valids, and sets step to 1.0. No clearing pass.
`include "assert_macros.svh"

module linear_interp_resampler
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lir_pkg::STEP_BITS-1:0]   cfg_wr_data,
    lir_in_if.sink                          samples,
    lir_out_if.source                       results
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    lir_pkg::state_t                  state_reg, state_next;
    logic [lir_pkg::STEP_BITS-1:0]    step_reg;
    logic [lir_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic [lir_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             primed_reg, primed_next;
    logic                             s1_valid_reg, s1_last_reg;

    logic [lir_pkg::STEP_BITS-1:0]    eff_step;
    logic [lir_pkg::PHASE_W-1:0]      phase_sum;
    logic                             accept;
    logic                             advance;
    logic                             issue;
    logic                             issue_last;
    lir_pkg::lane_ctl_t               lane_ctl;
    lir_pkg::beat_ctl_t               s1_ctl;
    lir_pkg::frame_t                  frame_in;
    lir_pkg::frame_t                  lane_result;

    // Steps below 1/64 are raised so one frame never exceeds 64 outputs.
    assign eff_step  = (step_reg < lir_pkg::MIN_STEP) ? lir_pkg::MIN_STEP : step_reg;
    // phase is below 1.0 whenever this is used, so it cannot overflow
    assign phase_sum = phase_reg + lir_pkg::PHASE_W'(eff_step);

    // Input is taken only between frames.
    assign samples.ready = (state_reg == lir_pkg::ST_IDLE);
    assign accept        = samples.valid && samples.ready;

    assign frame_in[0] = samples.sample_ch0;
    assign frame_in[1] = samples.sample_ch1;

    // ------------------------------------------------------------------
    // Sequencer: next state and lane controls
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        primed_next      = primed_reg;
        issue            = 1'b0;
        issue_last       = 1'b0;
        lane_ctl.load_cur  = 1'b0;
        lane_ctl.load_prev = 1'b0;
        lane_ctl.commit    = 1'b0;
        lane_ctl.advance   = advance;

        unique case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    lane_ctl.load_cur = 1'b1;
                    if (primed_reg)
                    begin
                        state_next = lir_pkg::ST_RUN;
                    end
                    else
                    begin
                        // first frame only seeds the previous-frame store
                        lane_ctl.load_prev = 1'b1;
                        primed_next        = 1'b1;
                    end
                end
            end
            lir_pkg::ST_RUN:
            begin
                if (phase_reg >= lir_pkg::PHASE_ONE)
                begin
                    // downsampling: this frame is skipped over
                    phase_next      = phase_reg - lir_pkg::PHASE_ONE;
                    lane_ctl.commit = 1'b1;
                    state_next      = lir_pkg::ST_IDLE;
                end
                else if (advance)
                begin
                    issue      = 1'b1;
                    issue_last = (phase_sum >= lir_pkg::PHASE_ONE) ||
                                 (cnt_reg == lir_pkg::CNT_LAST);
                    if (issue_last)
                    begin
                        phase_next      = (phase_sum >= lir_pkg::PHASE_ONE) ?
                                          phase_sum - lir_pkg::PHASE_ONE : '0;
                        cnt_next        = '0;
                        lane_ctl.commit = 1'b1;
                        state_next      = lir_pkg::ST_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_sum;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = lir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lir_pkg::ST_IDLE;
            phase_reg  <= '0;
            cnt_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            primed_reg <= primed_next;
        end
    end

    // Step register: written any time the write enable is up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= lir_pkg::STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            step_reg <= cfg_wr_data;
        end
    end

    // Stage-1 slot status (product registers live in the lanes).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= issue;
            s1_last_reg  <= issue_last;
        end
    end

    assign s1_ctl.valid = s1_valid_reg;
    assign s1_ctl.last  = s1_last_reg;

    // ------------------------------------------------------------------
    // Lanes: one multiply-add datapath per channel, sharing the phase
    // ------------------------------------------------------------------
    for (genvar ch = 0; ch < lir_pkg::CHANNELS; ch++)
    begin : g_lane
        lir_lane u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .sample (frame_in[ch]),
            .frac   (phase_reg[lir_pkg::FRAC_BITS-1:0]),
            .result (lane_result[ch])
        );
    end

    // Merge: output register and backpressure
    lir_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .lane_result (lane_result),
        .s1          (s1_ctl),
        .advance     (advance),
        .results     (results)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `LIR_ASSERT(a_issue_frac, issue |-> (phase_reg < lir_pkg::PHASE_ONE), "issue with phase >= 1")
    `LIR_ASSERT_ALWAYS(a_idle_phase, (state_reg == lir_pkg::ST_IDLE) |-> (phase_reg < lir_pkg::PHASE_BOUND), "phase out of range between frames")
    `LIR_ASSERT(a_prime_quiet, (accept && !primed_reg) |=> ((state_reg == lir_pkg::ST_IDLE) && !s1_valid_reg), "priming frame produced work")

endmodule

// ----- design/lir_lane.sv -----
// lir_lane: one channel of the interpolator: frame store, multiply stage, final add.
// Depends on lir_pkg.
module lir_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  lir_pkg::lane_ctl_t  ctl,
    input  lir_pkg::sample_t    sample,
    input  lir_pkg::frac_t      frac,
    output lir_pkg::sample_t    result
);

    lir_pkg::sample_t                    cur_reg;
    lir_pkg::sample_t                    prev_reg;
    lir_pkg::sample_t                    prev_next;
    lir_pkg::sample_t                    base_reg;
    logic signed [lir_pkg::PROD_W-1:0]   prod_reg;
    logic signed [lir_pkg::DIFF_W-1:0]   diff;
    logic signed [lir_pkg::DIFF_W:0]     prod_full_hi;
    logic signed [2*lir_pkg::DIFF_W-1:0] prod_full;
    logic signed [lir_pkg::DIFF_W:0]     sum;

    assign diff = lir_pkg::DIFF_W'(cur_reg) - lir_pkg::DIFF_W'(prev_reg);
    assign prod_full = diff * $signed({1'b0, frac});

    always_comb
    begin
        prev_next = prev_reg;
        if (ctl.load_prev)
        begin
            prev_next = sample;
        end
        else if (ctl.commit)
        begin
            prev_next = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_cur)
        begin
            cur_reg <= sample;
        end
        if (ctl.advance)
        begin
            prod_reg <= lir_pkg::PROD_W'(prod_full);
            base_reg <= prev_reg;
        end
    end

    // floor division by 2^16 (1.0 in the phase format): arithmetic shift
    assign prod_full_hi = (lir_pkg::DIFF_W+1)'(prod_reg >>> lir_pkg::FRAC_BITS);
    assign sum          = (lir_pkg::DIFF_W+1)'(base_reg) + prod_full_hi;
    assign result       = lir_pkg::SAMPLE_BITS'(sum);

endmodule

// ----- design/lir_merge.sv -----
// lir_merge: gathers lane results into the output register and drives the output channel.
// Depends on lir_pkg and lir_out_if.
module lir_merge
(
    input  logic                clk,
    input  logic                rst_n,
    input  lir_pkg::frame_t     lane_result,
    input  lir_pkg::beat_ctl_t  s1,
    output logic                advance,
    lir_out_if.source           results
);

    lir_pkg::frame_t  out_reg;
    logic             last_reg;
    logic             valid_reg;
    logic             valid_next;

    assign advance    = !valid_reg || results.ready;
    assign valid_next = advance ? s1.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg  <= lane_result;
            last_reg <= s1.last;
        end
    end

    assign results.valid   = valid_reg;
    assign results.out_ch0 = out_reg[0];
    assign results.out_ch1 = out_reg[1];
    assign results.last    = last_reg;

endmodule
